@@ rtl/swdm_pkg.sv @@
package swdm_pkg;

  localparam int unsigned SWDM_LINES = 192;
  localparam int unsigned SWDM_COLS = 32;
  localparam int unsigned SWDM_ADDR_W = $clog2(SWDM_LINES);
  localparam int unsigned SWDM_QUEUE_DEPTH = 2;

  localparam logic [13:0] SWDM_ATTR_BASE     = 14'h1800;
  localparam logic [13:0] SWDM_ATTR_END      = 14'h1b00;
  localparam logic [13:0] SWDM_ALT_OFFSET    = 14'h2000;
  localparam logic [13:0] SWDM_ALT_ATTR_BASE = 14'h3800;
  localparam logic [13:0] SWDM_ALT_ATTR_END  = 14'h3b00;

  typedef enum logic [1:0] {
    OP_MARK    = 2'd0,
    OP_TAKE    = 2'd1,
    OP_REFRESH = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_MARK,
    CMD_TAKE,
    CMD_REFRESH
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                kind;
    logic [SWDM_ADDR_W-1:0]   line;
    logic [2:0]               last;
    logic [SWDM_COLS-1:0]     mask;
    logic [4:0]               shift;
  } swdm_cmd_t;

endpackage

@@ rtl/swdm_front.sv @@
module swdm_front (
  input  logic [2:0]          screen_mode_i,
  input  logic [1:0]          opcode_i,
  input  logic [13:0]         write_offset_i,
  input  logic [7:0]          line_i,
  input  logic [5:0]          start_col_i,
  input  logic [5:0]          end_col_i,
  output swdm_pkg::swdm_cmd_t cmd_o
);
  import swdm_pkg::*;

  typedef enum logic [1:0] {
    LAYOUT_STD,
    LAYOUT_ALT,
    LAYOUT_EXT,
    LAYOUT_EXT_ALT
  } layout_e;

  logic [13:0]          off;
  logic                 is_bm;
  logic                 is_attr;
  logic [7:0]           bm_line;
  logic [7:0]           attr_line;
  logic [5:0]           end_clamp;
  logic                 empty;
  logic [SWDM_COLS-1:0] lo_mask;
  logic [SWDM_COLS-1:0] hi_mask;

  assign off       = write_offset_i;
  assign bm_line   = {off[12:11], off[7:5], off[10:8]};
  assign attr_line = {off[9:5], 3'b000};

  always_comb begin
    is_bm   = 1'b0;
    is_attr = 1'b0;
    unique case (layout_e'(screen_mode_i[2:1]))
      LAYOUT_STD: begin
        is_bm   = off < SWDM_ATTR_BASE;
        is_attr = (off >= SWDM_ATTR_BASE) && (off < SWDM_ATTR_END);
      end
      LAYOUT_ALT: begin
        is_bm   = (off >= SWDM_ALT_OFFSET) && (off < SWDM_ALT_ATTR_BASE);
        is_attr = (off >= SWDM_ALT_ATTR_BASE) && (off < SWDM_ALT_ATTR_END);
      end
      LAYOUT_EXT: begin
        is_bm = (off < SWDM_ATTR_BASE) ||
                ((off >= SWDM_ALT_OFFSET) && (off < SWDM_ALT_ATTR_BASE));
      end
      LAYOUT_EXT_ALT: begin
        is_bm = (off >= SWDM_ALT_OFFSET) && (off < SWDM_ALT_ATTR_BASE);
      end
    endcase
  end

  assign end_clamp = (end_col_i > 6'd32) ? 6'd32 : end_col_i;
  assign empty     = (line_i >= 8'(SWDM_LINES)) || start_col_i[5] ||
                     (end_clamp <= start_col_i);
  assign lo_mask   = {SWDM_COLS{1'b1}} << start_col_i[4:0];
  assign hi_mask   = end_clamp[5] ? {SWDM_COLS{1'b1}}
                                  : ((SWDM_COLS'(1) << end_clamp[4:0]) - SWDM_COLS'(1));

  always_comb begin
    cmd_o.kind  = CMD_NONE;
    cmd_o.line  = '0;
    cmd_o.last  = '0;
    cmd_o.mask  = '0;
    cmd_o.shift = '0;
    unique case (opcode_e'(opcode_i))
      OP_MARK: begin
        cmd_o.kind = (is_bm || is_attr) ? CMD_MARK : CMD_NONE;
        cmd_o.line = is_attr ? attr_line : bm_line;
        cmd_o.last = is_attr ? 3'd7 : 3'd0;
        cmd_o.mask = SWDM_COLS'(1) << off[4:0];
      end
      OP_TAKE: begin
        cmd_o.kind  = empty ? CMD_NONE : CMD_TAKE;
        cmd_o.line  = line_i;
        cmd_o.mask  = lo_mask & hi_mask;
        cmd_o.shift = start_col_i[4:0];
      end
      OP_REFRESH: begin
        cmd_o.kind = CMD_REFRESH;
      end
      default: begin
        cmd_o.kind = CMD_NONE;
      end
    endcase
  end

endmodule

@@ rtl/swdm_fifo.sv @@
module swdm_fifo #(
  parameter int unsigned DEPTH = swdm_pkg::SWDM_QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  swdm_pkg::swdm_cmd_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output swdm_pkg::swdm_cmd_t data_o
);
  import swdm_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  swdm_cmd_t        entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
    else $error("queue count lost a push");
`endif

endmodule

@@ rtl/swdm_back.sv @@
module swdm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  swdm_pkg::swdm_cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         dirty_bits_o
);
  import swdm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_MODIFY
  } state_e;

  state_e                 state_q, state_d;
  swdm_cmd_t              cmd_q, cmd_d;
  logic [SWDM_ADDR_W-1:0] line_q, line_d;
  logic [2:0]             cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [31:0]            dirty_bits_q, dirty_bits_d;

  logic [SWDM_COLS-1:0]   mem_q [SWDM_LINES];
  logic [SWDM_COLS-1:0]   rdata_q;
  logic [SWDM_LINES-1:0]  valid_q;
  logic                   rvalid_q;

  logic                   slot_free;
  logic                   rd_en;
  logic [SWDM_ADDR_W-1:0] rd_addr;
  logic                   wr_en;
  logic                   refresh;
  logic [SWDM_COLS-1:0]   word;
  logic [SWDM_COLS-1:0]   new_word;
  logic [SWDM_COLS-1:0]   take_bits;

  assign slot_free = !out_valid_q || out_ready_i;
  assign word      = rvalid_q ? rdata_q : {SWDM_COLS{1'b1}};
  assign new_word  = (cmd_q.kind == CMD_TAKE) ? (word & ~cmd_q.mask) : (word | cmd_q.mask);
  assign take_bits = (word & cmd_q.mask) >> cmd_q.shift;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    line_d       = line_q;
    cnt_d        = cnt_q;
    dirty_bits_d = dirty_bits_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;
    cmd_pop_o    = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = cmd_i.line;
    wr_en        = 1'b0;
    refresh      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == CMD_MARK || cmd_i.kind == CMD_TAKE) begin
            cmd_pop_o = 1'b1;
            rd_en     = 1'b1;
            cmd_d     = cmd_i;
            line_d    = cmd_i.line;
            cnt_d     = cmd_i.last;
            state_d   = ST_MODIFY;
          end else if (slot_free) begin
            cmd_pop_o    = 1'b1;
            refresh      = cmd_i.kind == CMD_REFRESH;
            out_valid_d  = 1'b1;
            dirty_bits_d = '0;
          end
        end
      end
      ST_MODIFY: begin
        if (cnt_q != '0) begin
          wr_en   = 1'b1;
          rd_en   = 1'b1;
          rd_addr = SWDM_ADDR_W'(line_q + 1'b1);
          line_d  = rd_addr;
          cnt_d   = 3'(cnt_q - 1'b1);
        end else if (slot_free) begin
          wr_en        = 1'b1;
          out_valid_d  = 1'b1;
          dirty_bits_d = (cmd_q.kind == CMD_TAKE) ? take_bits : '0;
          state_d      = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= '0;
      line_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      dirty_bits_q <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      line_q       <= line_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      dirty_bits_q <= dirty_bits_d;
    end
  end

  // line words are valid only once written since reset or the last refresh
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (refresh) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[line_q] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= valid_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[line_q] <= new_word;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dirty_bits_o = dirty_bits_q;

`ifndef SYNTHESIS
  a_modify_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY) |-> (cmd_q.kind == CMD_MARK || cmd_q.kind == CMD_TAKE))
    else $error("map update without mark or take");
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY) |-> (line_q < SWDM_ADDR_W'(SWDM_LINES)))
    else $error("map line out of range");
  a_take_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MODIFY && cmd_q.kind == CMD_TAKE) |-> (cnt_q == '0))
    else $error("take spans more than one line");
  a_refresh_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refresh |=> (valid_q == '0))
    else $error("refresh left line words valid");
`endif

endmodule

@@ rtl/screen_write_dirty_map_core.sv @@
// screen write dirty map
// keeps one 32-bit chunk mask per display line (192 lines), all set at reset.
// input channel in_valid_i/in_ready_o carries one transaction per item:
//   opcode_i mark (write_offset_i decoded per screen_mode), take
//   (line_i, start_col_i, end_col_i) or refresh.
// output channel out_valid_o/out_ready_i returns exactly one dirty_bits_o per
// item, in order; it is zero for everything but a take.
// screen_mode is written through the apb port at address 0; the user must write
// it only while idle, the block itself does not enforce this. an accepted item
// is registered in the queue; a mark or take reads its first map line into the
// read register, then read-modify-writes the single map ram one line per cycle,
// the last write waiting for a free result slot, and registers its result while
// later items wait in the queue. refresh, empty takes and ignored items go straight
// to the result register when it is free. reset clears all line valid flags at
// once, so the map reads all ones with no clearing pass; refresh does the same.
// a stalled receiver holds the result register; the queue keeps taking
// items until full, then in_ready_o drops.
module screen_write_dirty_map_core #(
  parameter int unsigned QUEUE_DEPTH = swdm_pkg::SWDM_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [13:0] write_offset_i,
  input  logic [7:0]  line_i,
  input  logic [5:0]  start_col_i,
  input  logic [5:0]  end_col_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] dirty_bits_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import swdm_pkg::*;

  logic [2:0] screen_mode_q;
  swdm_cmd_t  front_cmd;
  swdm_cmd_t  queue_cmd;
  logic       queue_full;
  logic       queue_valid;
  logic       queue_pop;
  logic       push;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {29'd0, screen_mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_mode_q <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      screen_mode_q <= pwdata[2:0];
    end
  end

  assign in_ready_o = !queue_full;
  assign push       = in_valid_i && in_ready_o;

  swdm_front u_front (
    .screen_mode_i  (screen_mode_q),
    .opcode_i       (opcode_i),
    .write_offset_i (write_offset_i),
    .line_i         (line_i),
    .start_col_i    (start_col_i),
    .end_col_i      (end_col_i),
    .cmd_o          (front_cmd)
  );

  swdm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .data_o  (queue_cmd)
  );

  swdm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (queue_valid),
    .cmd_i        (queue_cmd),
    .cmd_pop_o    (queue_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dirty_bits_o (dirty_bits_o)
  );

endmodule
